/* rtl/utf8v_pkg.sv */
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types, constants and byte classification functions of the UTF-8
// validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

  localparam int unsigned OFFSET_BITS = 48;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned MAX_RESULTS = 6;

  // Replacement character U+FFFD in UTF-8.
  localparam logic [7:0] REPL_B0 = 8'hef;
  localparam logic [7:0] REPL_B1 = 8'hbf;
  localparam logic [7:0] REPL_B2 = 8'hbd;

  // Operation codes carried on the input tuser.
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // One bundle of results made by a single input item.
  typedef struct packed {
    logic [2:0]                       count;
    logic [MAX_RESULTS-1:0][7:0]      bytes;
    logic                             err;
    logic [OFFSET_BITS-1:0]           offset;
    logic [COUNT_BITS-1:0]            total_lo;  // total for results 0 to 2
    logic [COUNT_BITS-1:0]            total_hi;  // total for results 3 to 5
  } bundle_t;

  function automatic logic is_cont(logic [7:0] b);
    return (b >= 8'h80) && (b <= 8'hbf);
  endfunction

  // Sequence length announced by a lead byte; zero for a byte that cannot lead.
  function automatic logic [2:0] lead_len(logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b <= 8'h7f) len = 3'd1;
    else if (b >= 8'hc2 && b <= 8'hdf) len = 3'd2;
    else if (b >= 8'he0 && b <= 8'hef) len = 3'd3;
    else if (b >= 8'hf0 && b <= 8'hf4) len = 3'd4;
    return len;
  endfunction

  // The second byte rules out overlong forms, surrogates and values
  // above U+10FFFF.
  function automatic logic second_ok(logic [7:0] lead, logic [7:0] b);
    logic ok;
    ok = is_cont(b);
    if (lead == 8'he0) ok = ok && (b >= 8'ha0);
    else if (lead == 8'hed) ok = ok && (b <= 8'h9f);
    else if (lead == 8'hf0) ok = ok && (b >= 8'h90);
    else if (lead == 8'hf4) ok = ok && (b <= 8'h8f);
    return ok;
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] r;
    r = (c == '1) ? c : c + COUNT_BITS'(1);
    return r;
  endfunction

endpackage

/* rtl/utf8v_core.sv */
// ----------------------------------------------------------------------------
// utf8v_core
// Input register, sequence state and the per-item decision logic that turns
// one registered item into a bundle of results.
// ----------------------------------------------------------------------------
module utf8v_core
  import utf8v_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    in_op_i,
  input  logic [7:0] in_byte_i,
  input  logic    cfg_we_i,
  input  logic    cfg_wdata_i,
  input  logic    can_load_i,
  output logic    bun_valid_o,
  output bundle_t bun_o
);

  logic                   in_valid_q;
  logic                   op_q;
  logic [7:0]             byte_q;
  logic                   reject_q;
  logic [1:0]             hc_q, hc_d;
  logic [2:0]             el_q, el_d;
  logic [2:0][7:0]        held_q, held_d;
  logic [OFFSET_BITS-1:0] ss_q, ss_d;
  logic [OFFSET_BITS-1:0] bp_q, bp_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic                   halted_q, halted_d;

  logic       adv;
  logic       ok, cont_ok, complete, brk, lead_phase;
  logic [2:0] len;
  logic [1:0] ninc;
  logic [COUNT_BITS-1:0] cnt1, cnt2;
  bundle_t    bun;

  assign adv        = in_valid_q && can_load_i;
  assign in_ready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      reject_q   <= 1'b0;
      hc_q       <= '0;
      el_q       <= '0;
      ss_q       <= '0;
      bp_q       <= '0;
      cnt_q      <= '0;
      halted_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        reject_q <= cfg_wdata_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        hc_q     <= hc_d;
        el_q     <= el_d;
        ss_q     <= ss_d;
        bp_q     <= bp_d;
        cnt_q    <= cnt_d;
        halted_q <= halted_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= in_op_i;
      byte_q <= in_byte_i;
    end
    if (adv) begin
      held_q <= held_d;
    end
  end

  assign len      = lead_len(byte_q);
  assign ok       = (hc_q == 2'd1) ? second_ok(held_q[0], byte_q) : is_cont(byte_q);
  assign cont_ok  = (op_q == OP_DATA) && (hc_q != 2'd0) && ok;
  assign complete = ({1'b0, hc_q} + 3'd1) >= el_q;
  assign brk      = (hc_q != 2'd0) && ((op_q == OP_FLUSH) || !ok);
  assign lead_phase = (op_q == OP_DATA) && !cont_ok && !(brk && reject_q);
  assign cnt1     = sat_inc(cnt_q);
  assign cnt2     = sat_inc(cnt1);

  always_comb begin
    bun       = '0;
    hc_d      = hc_q;
    el_d      = el_q;
    held_d    = held_q;
    ss_d      = ss_q;
    bp_d      = bp_q;
    halted_d  = halted_q;
    ninc      = 2'd0;
    if (!halted_q) begin
      if (op_q == OP_DATA) begin
        bp_d = bp_q + OFFSET_BITS'(1);
      end
      if (cont_ok) begin
        if (complete) begin
          bun.bytes[0]    = held_q[0];
          bun.bytes[1]    = held_q[1];
          bun.bytes[2]    = held_q[2];
          bun.bytes[{1'b0, hc_q}] = byte_q;
          bun.count       = {1'b0, hc_q} + 3'd1;
          hc_d            = '0;
          el_d            = '0;
        end else begin
          held_d[hc_q] = byte_q;
          hc_d         = hc_q + 2'd1;
        end
      end else begin
        // A broken or unfinished sequence is reported at its start.
        if (brk) begin
          hc_d = '0;
          el_d = '0;
          if (reject_q) begin
            bun.count  = 3'd1;
            bun.err    = 1'b1;
            bun.offset = ss_q;
            halted_d   = 1'b1;
          end else begin
            bun.bytes[0] = REPL_B0;
            bun.bytes[1] = REPL_B1;
            bun.bytes[2] = REPL_B2;
            bun.count    = 3'd3;
            ninc         = 2'd1;
          end
        end
        // Unless the sequence was rejected, a data byte then acts as a lead byte.
        if (lead_phase) begin
          case (len)
            3'd1: begin
              bun.bytes[bun.count] = byte_q;
              bun.count            = bun.count + 3'd1;
            end
            3'd0: begin
              if (reject_q) begin
                bun.count  = 3'd1;
                bun.err    = 1'b1;
                bun.offset = bp_q;
                halted_d   = 1'b1;
              end else begin
                bun.bytes[bun.count]        = REPL_B0;
                bun.bytes[bun.count + 3'd1] = REPL_B1;
                bun.bytes[bun.count + 3'd2] = REPL_B2;
                bun.count                   = bun.count + 3'd3;
                ninc                        = ninc + 2'd1;
              end
            end
            default: begin
              held_d[0] = byte_q;
              hc_d      = 2'd1;
              el_d      = len;
              ss_d      = bp_q;
            end
          endcase
        end
      end
    end
    bun.total_lo = (ninc != 2'd0) ? cnt1 : cnt_q;
    bun.total_hi = (ninc == 2'd2) ? cnt2 : bun.total_lo;
    cnt_d        = bun.total_hi;
  end

  assign bun_o       = bun;
  assign bun_valid_o = adv && (bun.count != 3'd0);

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hc_q != 2'd0) |-> ({1'b0, hc_q} < el_q))
    else $error("held byte count reached the expected length");

  a_halt_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !bun_valid_o)
    else $error("result produced while halted");

endmodule

/* rtl/utf8v_outbuf.sv */
// ----------------------------------------------------------------------------
// utf8v_outbuf
// Result register that holds one bundle and hands its results out one item
// per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module utf8v_outbuf
  import utf8v_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bun_i,
  output logic    can_load_o,
  output logic    valid_o,
  input  logic    ready_i,
  output logic [7:0] byte_o,
  output logic    last_o,
  output logic    err_o,
  output logic [OFFSET_BITS-1:0] offset_o,
  output logic [COUNT_BITS-1:0]  total_o
);

  logic       valid_q;
  logic [2:0] idx_q;
  bundle_t    bun_q;
  logic       pop;

  assign pop        = valid_q && ready_i;
  assign last_o     = (idx_q + 3'd1) == bun_q.count;
  assign can_load_o = !valid_q || (pop && last_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (pop) begin
      if (last_o) begin
        valid_q <= 1'b0;
      end
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bun_q <= bun_i;
    end
  end

  assign valid_o  = valid_q;
  assign byte_o   = bun_q.bytes[idx_q];
  assign err_o    = bun_q.err;
  assign offset_o = bun_q.offset;
  assign total_o  = (idx_q >= 3'd3) ? bun_q.total_hi : bun_q.total_lo;

  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && bun_q.err) |-> (bun_q.count == 3'd1))
    else $error("error result shares its bundle with other results");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (idx_q < bun_q.count))
    else $error("result index beyond bundle size");

endmodule

/* rtl/utf8_validate_replace.sv */
// ----------------------------------------------------------------------------
// utf8_validate_replace
// Streaming UTF-8 validator: passes well-formed sequences, replaces or
// rejects malformed ones.
// ----------------------------------------------------------------------------
// An accepted byte passes the input register and then the result register.
// Throughput: one input item per cycle while each makes at most one result
// and the receiver is ready; an item that makes several results holds the
// input until the result register has handed all of them out, one per cycle.
// Reset: rst_ni clears the sequence state, counters, halt flag and mode
// asynchronously; the held byte store is not reset and needs no clearing.
module utf8_validate_replace
  import utf8v_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] operation (0 data, 1 end of stream)
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,   // [7:0] out_byte, [55:8] error_offset,
                                      // [87:56] invalid_total
  output logic        m_axis_tlast,   // last result of the input item
  output logic        m_axis_tuser,   // [0] error
  // Mode register: 0 replaces bad sequences, 1 stops at the first one.
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i
);

  // The core decides everything about one item from its input register
  // and drops the results as a bundle into the output buffer.
  // The core advances only when the buffer is empty or is handing out the
  // last result of its current bundle, so items never overtake each other.
  bundle_t                bun;
  logic                   bun_valid;
  logic                   can_load;
  logic [7:0]             out_byte;
  logic                   out_err;
  logic [OFFSET_BITS-1:0] out_offset;
  logic [COUNT_BITS-1:0]  out_total;

  utf8v_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .can_load_i  (can_load),
    .bun_valid_o (bun_valid),
    .bun_o       (bun)
  );

  // Holds one bundle of up to six results and serializes it.
  utf8v_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (bun_valid),
    .bun_i      (bun),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .byte_o     (out_byte),
    .last_o     (m_axis_tlast),
    .err_o      (out_err),
    .offset_o   (out_offset),
    .total_o    (out_total)
  );

  // Fields packed from the lowest bit up; the width is a whole number of bytes.
  assign m_axis_tdata = {out_total, out_offset, out_byte};
  assign m_axis_tuser = out_err;

endmodule
